// ----- rtl/mva_pkg.sv -----
// ----------------------------------------------------------------------------
// mva_pkg: shared types and constants of the vertex normal accumulator
// Item layouts, queue command format, state encodings and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mva_pkg;

  // Sizing
  localparam int MAX_VERTICES = 4096;
  localparam int SUM_WIDTH    = 20;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int POS_W        = 24;
  localparam int EDGE_W       = POS_W + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int VEC_W        = 52;
  localparam int NRM_W        = 16;
  localparam int FRAC_W       = 14;
  localparam int ONE_Q14      = 1 << FRAC_W;
  localparam int QDEPTH       = 2;

  // Input kinds
  localparam logic [1:0] KIND_WPOS = 2'd0;
  localparam logic [1:0] KIND_TRI  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [1:0] KIND_QUAD = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic [11:0]              vertex_a;
    logic [11:0]              vertex_b;
    logic [11:0]              vertex_c;
    logic [11:0]              vertex_d;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    zero_normal;
  } out_item_t;

  // Commands passed from front to back
  typedef enum logic [1:0] {
    OP_WPOS,
    OP_TRI,
    OP_READ,
    OP_READ_ZERO
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [VIDX_W-1:0]       va;
    logic [VIDX_W-1:0]       vb;
    logic [VIDX_W-1:0]       vc;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
  } cmd_t;

  // Back status seen by the front
  typedef struct packed {
    logic init_done;
    logic pop;
  } bk_stat_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_WPOS,
    B_RDA,
    B_RDB,
    B_RDC,
    B_RDW,
    B_EDGE,
    B_MUL,
    B_RDS,
    B_RDSW,
    B_NGO,
    B_NWAIT,
    B_ACCR,
    B_ACCW,
    B_OUTZ
  } bstate_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DLD,
    N_DIV,
    N_DONE
  } nstate_e;

endpackage

`default_nettype wire

// ----- rtl/mesh_vertex_normal_accumulator.sv -----
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator: smooth per-vertex normals of a mesh
// Stores vertex positions, accumulates unit face normals per vertex and
// returns normalized vertex normals on request.
// ----------------------------------------------------------------------------
// After reset the block sweeps the normal-sum memory clear, one entry per
// cycle, and holds busy high meanwhile. Items go into a two-entry command
// queue; busy is high while the queue is full or while the second half of a
// quad is being queued. The back end runs one command at a time: a position
// write; a triangle (three position reads, six products on one multiplier,
// then the normalizer: up to 29 scaling steps, squaring, 32 square-root steps
// and a divide per component, then three accumulator read-modify-writes,
// which a degenerate face skips along with most of the normalizer); a quad as
// two triangles; or a normal read through the normalizer. The normalizer is
// the limiting unit. A result is shown for one cycle on result_valid_o and
// must be taken then; the receiver cannot stall it.
`default_nettype none

module mesh_vertex_normal_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mva_pkg::in_item_t  item_i,
  output logic               result_valid_o,
  output mva_pkg::out_item_t result_o
);

  import mva_pkg::*;

  cmd_t     cmd;
  logic     cmd_valid;
  bk_stat_t stat;

  mva_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy_o      (busy),
    .item_i      (item_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  mva_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cmd_valid_i    (cmd_valid),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

// ----- rtl/mva_ram.sv -----
// ----------------------------------------------------------------------------
// mva_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/mva_norm.sv -----
// ----------------------------------------------------------------------------
// mva_norm: iterative vector normalizer
// Scales a 3-vector so its largest magnitude is in [2^29, 2^30), sums the
// squares, takes an integer square root one bit pair a cycle and divides
// each component with a restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_norm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [mva_pkg::VEC_W-1:0]  vec_i [3],
  output logic                              done_o,
  output logic                              zero_o,
  output logic signed [mva_pkg::NRM_W-1:0]  nrm_o [3]
);

  import mva_pkg::*;

  localparam int NMAG_W  = 30;
  localparam int SUMSQ_W = 2 * NMAG_W + 2;
  localparam int ROOT_W  = SUMSQ_W + 1;
  localparam int LEN_W   = 32;
  localparam int REM_W   = NMAG_W + FRAC_W + 3;
  localparam int Q_W     = 16;
  localparam int J_W     = $clog2(Q_W);

  nstate_e state_q, state_d;

  logic [VEC_W-1:0]      mag_q [3];
  logic                  neg_q [3];
  logic                  zero_q;
  logic signed [NRM_W-1:0] nrm_q [3];
  logic [1:0]            cnt_q;
  logic [1:0]            ci_q;
  logic [J_W-1:0]        j_q;
  logic [2*NMAG_W-1:0]   sq_q;
  logic [SUMSQ_W-1:0]    s_q;
  logic [ROOT_W-1:0]     x_q, r_q, bit_q;
  logic [REM_W-1:0]      rem_q;
  logic [Q_W-1:0]        q_q;

  logic [VEC_W-1:0]      m01, mx, sq_src, dv_mag;
  logic                  big, low_mag;
  logic [ROOT_W:0]       rb;
  logic                  root_ge;
  logic [LEN_W-1:0]      len;
  logic [REM_W-1:0]      trial;
  logic                  div_ge;
  logic [Q_W-1:0]        q_new, q_clip;
  logic signed [NRM_W-1:0] q_sgn;

  // Largest magnitude and range test
  always_comb begin
    m01     = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
    mx      = (m01 > mag_q[2]) ? m01 : mag_q[2];
    big     = |mx[VEC_W-1:NMAG_W];
    low_mag = ~mx[NMAG_W-1];
  end

  // Square root step
  always_comb begin
    rb      = {1'b0, r_q} + {1'b0, bit_q};
    root_ge = {1'b0, x_q} >= rb;
  end

  // Division step
  always_comb begin
    sq_src = (cnt_q == 2'd2) ? mag_q[2] : ((cnt_q == 2'd1) ? mag_q[1] : mag_q[0]);
    dv_mag = mag_q[ci_q];
    len    = r_q[LEN_W-1:0];
    trial  = REM_W'(len) << j_q;
    div_ge = rem_q >= trial;
    q_new  = q_q | (div_ge ? (Q_W'(1) << j_q) : '0);
    q_clip = (q_new > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : q_new;
    q_sgn  = neg_q[ci_q] ? -$signed(NRM_W'(q_clip)) : $signed(NRM_W'(q_clip));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      N_IDLE:  if (start_i) state_d = N_SHIFT;
      N_SHIFT: begin
        if (mx == '0) begin
          state_d = N_DONE;
        end else if (!big && !low_mag) begin
          state_d = N_SQ;
        end
      end
      N_SQ:    if (cnt_q == 2'd3) state_d = N_SQRT;
      N_SQRT:  if (bit_q[0]) state_d = N_DLD;
      N_DLD:   state_d = N_DIV;
      N_DIV: begin
        if (j_q == '0) begin
          state_d = (ci_q == 2'd2) ? N_DONE : N_DLD;
        end
      end
      N_DONE:  state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done_o = (state_q == N_DONE);
    zero_o = zero_q;
    nrm_o  = nrm_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      ci_q    <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == N_SQ) begin
        cnt_q <= cnt_q + 2'd1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == N_SQRT) begin
        ci_q <= '0;
      end else if (state_q == N_DIV && j_q == '0) begin
        ci_q <= ci_q + 2'd1;
      end
      if (state_q == N_DLD) begin
        j_q <= J_W'(Q_W - 1);
      end else if (state_q == N_DIV) begin
        j_q <= j_q - J_W'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          zero_q <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vec_i[i][VEC_W-1];
            mag_q[i] <= vec_i[i][VEC_W-1] ? VEC_W'(-vec_i[i]) : VEC_W'(vec_i[i]);
          end
        end
      end
      N_SHIFT: begin
        if (mx == '0) begin
          zero_q <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            nrm_q[i] <= '0;
          end
        end else if (big) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
        end else if (low_mag) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= mag_q[i] << 1;
          end
        end
      end
      N_SQ: begin
        sq_q <= sq_src[NMAG_W-1:0] * sq_src[NMAG_W-1:0];
        s_q  <= (cnt_q == 2'd0) ? '0 : s_q + SUMSQ_W'(sq_q);
        if (cnt_q == 2'd3) begin
          x_q   <= ROOT_W'(s_q) + ROOT_W'(sq_q);
          r_q   <= '0;
          bit_q <= {1'b1, {(ROOT_W-1){1'b0}}};
        end
      end
      N_SQRT: begin
        if (root_ge) begin
          x_q <= x_q - rb[ROOT_W-1:0];
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      N_DLD: begin
        rem_q <= REM_W'({dv_mag[NMAG_W-1:0], {FRAC_W{1'b0}}}) + REM_W'(len >> 1);
        q_q   <= '0;
      end
      N_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - trial;
        end
        q_q <= q_new;
        if (j_q == '0) begin
          nrm_q[ci_q] <= q_sgn;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mva_front.sv -----
// ----------------------------------------------------------------------------
// mva_front: item intake and command queue
// Range-checks each item, splits quads into two triangles and queues the
// resulting commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy_o,
  input  mva_pkg::in_item_t  item_i,
  input  mva_pkg::bk_stat_t  stat_i,
  output mva_pkg::cmd_t      cmd_o,
  output logic               cmd_valid_o
);

  import mva_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t              fifo_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              pend_q, pend_d;
  cmd_t              pend_cmd_q;

  cmd_t first_cmd, second_cmd, new_cmd, push_cmd;
  logic first_ok, second_ok, new_push, new_pend;
  logic full, accept, push, pop;

  function automatic logic in_range(logic [11:0] v);
    return {20'd0, v} < 32'(MAX_VERTICES);
  endfunction

  // Classify the incoming item
  always_comb begin
    first_cmd    = '0;
    first_cmd.op = OP_TRI;
    first_cmd.va = VIDX_W'(item_i.vertex_a);
    first_cmd.vb = VIDX_W'(item_i.vertex_b);
    first_cmd.vc = VIDX_W'(item_i.vertex_c);
    first_cmd.px = item_i.pos_x;
    first_cmd.py = item_i.pos_y;
    first_cmd.pz = item_i.pos_z;
    second_cmd    = first_cmd;
    second_cmd.vb = VIDX_W'(item_i.vertex_c);
    second_cmd.vc = VIDX_W'(item_i.vertex_d);
    first_ok  = 1'b0;
    second_ok = 1'b0;
    unique case (item_i.kind)
      KIND_WPOS: begin
        first_cmd.op = OP_WPOS;
        first_ok     = in_range(item_i.vertex_a);
      end
      KIND_TRI: begin
        first_ok = in_range(item_i.vertex_a) && in_range(item_i.vertex_b) &&
                   in_range(item_i.vertex_c);
      end
      KIND_READ: begin
        first_cmd.op = in_range(item_i.vertex_a) ? OP_READ : OP_READ_ZERO;
        first_ok     = 1'b1;
      end
      KIND_QUAD: begin
        first_ok  = in_range(item_i.vertex_a) && in_range(item_i.vertex_b) &&
                    in_range(item_i.vertex_c);
        second_ok = in_range(item_i.vertex_a) && in_range(item_i.vertex_c) &&
                    in_range(item_i.vertex_d);
      end
      default: ;
    endcase
    new_push = first_ok || second_ok;
    new_cmd  = first_ok ? first_cmd : second_cmd;
    new_pend = first_ok && second_ok;
  end

  // Queue control
  always_comb begin
    full     = (cnt_q == CNT_W'(QDEPTH));
    busy_o   = !stat_i.init_done || pend_q || full;
    accept   = start && !busy_o;
    push     = accept ? new_push : (pend_q && !full);
    push_cmd = accept ? new_cmd : pend_cmd_q;
    pop      = stat_i.pop;
    pend_d   = pend_q;
    if (accept) begin
      pend_d = new_pend;
    end else if (pend_q && !full) begin
      pend_d = 1'b0;
    end
    cmd_o       = fifo_q[rd_ptr_q];
    cmd_valid_o = (cnt_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Queue storage and held second half of a quad
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_cmd;
    end
    if (accept && new_pend) begin
      pend_cmd_q <= second_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mva_back.sv -----
// ----------------------------------------------------------------------------
// mva_back: command execution
// Holds the position and normal-sum memories, forms face normals with one
// shared multiplier, normalizes through the iterative unit and updates the
// per-vertex sums with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mva_pkg::cmd_t      cmd_i,
  input  logic               cmd_valid_i,
  output mva_pkg::bk_stat_t  stat_o,
  output logic               result_valid_o,
  output mva_pkg::out_item_t result_o
);

  import mva_pkg::*;

  localparam int PW = 3 * POS_W;
  localparam int SW = 3 * SUM_WIDTH;

  bstate_e state_q, state_d;

  cmd_t                    cmd_q;
  logic [VIDX_W-1:0]       clr_q;
  logic [2:0]              mcnt_q;
  logic [1:0]              k_q;
  logic signed [POS_W-1:0] pa_q [3], pb_q [3], pc_q [3];
  logic signed [EDGE_W-1:0] e1_q [3], e2_q [3];
  logic signed [PROD_W-1:0] prod_q;
  logic signed [VEC_W-1:0]  vec_q [3];
  logic                    res_valid_q;
  out_item_t               res_q;

  logic              pos_we, sum_we, nrm_start, pop;
  logic [VIDX_W-1:0] pos_raddr, sum_waddr, sum_raddr, acc_idx;
  logic [PW-1:0]     pos_wdata, pos_rdata;
  logic [SW-1:0]     sum_wdata, sum_rdata;
  logic signed [EDGE_W-1:0] op_a, op_b;
  logic [2:0]        mj;
  logic              nrm_done, nrm_zero;
  logic signed [NRM_W-1:0] nrm [3];

  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    logic signed [SUM_WIDTH-1:0] s, logic signed [NRM_W-1:0] n);
    logic signed [SUM_WIDTH:0] t;
    t = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(n);
    if (t[SUM_WIDTH] != t[SUM_WIDTH-1]) begin
      return t[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
    return t[SUM_WIDTH-1:0];
  endfunction

  function automatic logic signed [SUM_WIDTH-1:0] sum_fld(logic [SW-1:0] w, int i);
    return w[SW-1-i*SUM_WIDTH -: SUM_WIDTH];
  endfunction

  function automatic logic signed [POS_W-1:0] pos_fld(logic [PW-1:0] w, int i);
    return w[PW-1-i*POS_W -: POS_W];
  endfunction

  mva_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (cmd_q.va),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  mva_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  mva_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nrm_start),
    .vec_i   (vec_q),
    .done_o  (nrm_done),
    .zero_o  (nrm_zero),
    .nrm_o   (nrm)
  );

  // Corner select for accumulation
  always_comb begin
    case (k_q)
      2'd0:    acc_idx = cmd_q.va;
      2'd1:    acc_idx = cmd_q.vb;
      default: acc_idx = cmd_q.vc;
    endcase
  end

  // Cross product operand select
  always_comb begin
    mj = mcnt_q - 3'd1;
    case (mcnt_q)
      3'd0:    begin op_a = e1_q[1]; op_b = e2_q[2]; end
      3'd1:    begin op_a = e1_q[2]; op_b = e2_q[1]; end
      3'd2:    begin op_a = e1_q[2]; op_b = e2_q[0]; end
      3'd3:    begin op_a = e1_q[0]; op_b = e2_q[2]; end
      3'd4:    begin op_a = e1_q[0]; op_b = e2_q[1]; end
      3'd5:    begin op_a = e1_q[1]; op_b = e2_q[0]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: if (clr_q == VIDX_W'(MAX_VERTICES - 1)) state_d = B_IDLE;
      B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_WPOS:      state_d = B_WPOS;
            OP_TRI:       state_d = B_RDA;
            OP_READ:      state_d = B_RDS;
            OP_READ_ZERO: state_d = B_OUTZ;
            default:      state_d = B_IDLE;
          endcase
        end
      end
      B_WPOS:  state_d = B_IDLE;
      B_RDA:   state_d = B_RDB;
      B_RDB:   state_d = B_RDC;
      B_RDC:   state_d = B_RDW;
      B_RDW:   state_d = B_EDGE;
      B_EDGE:  state_d = B_MUL;
      B_MUL:   if (mcnt_q == 3'd6) state_d = B_NGO;
      B_RDS:   state_d = B_RDSW;
      B_RDSW:  state_d = B_NGO;
      B_NGO:   state_d = B_NWAIT;
      B_NWAIT: begin
        if (nrm_done) begin
          if (cmd_q.op == OP_READ || nrm_zero) begin
            state_d = B_IDLE;
          end else begin
            state_d = B_ACCR;
          end
        end
      end
      B_ACCR:  state_d = B_ACCW;
      B_ACCW:  state_d = (k_q == 2'd2) ? B_IDLE : B_ACCR;
      B_OUTZ:  state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Memory and control outputs
  always_comb begin
    pop       = 1'b0;
    pos_we    = 1'b0;
    pos_wdata = {cmd_q.px, cmd_q.py, cmd_q.pz};
    pos_raddr = cmd_q.va;
    sum_we    = 1'b0;
    sum_waddr = acc_idx;
    sum_wdata = '0;
    sum_raddr = acc_idx;
    nrm_start = 1'b0;
    unique case (state_q)
      B_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_q;
      end
      B_IDLE:  pop = cmd_valid_i;
      B_WPOS: begin
        pos_we    = 1'b1;
        sum_we    = 1'b1;
        sum_waddr = cmd_q.va;
      end
      B_RDA:   pos_raddr = cmd_q.va;
      B_RDB:   pos_raddr = cmd_q.vb;
      B_RDC:   pos_raddr = cmd_q.vc;
      B_RDS:   sum_raddr = cmd_q.va;
      B_NGO:   nrm_start = 1'b1;
      B_ACCW: begin
        sum_we    = 1'b1;
        sum_wdata = {sat_add(sum_fld(sum_rdata, 0), nrm[0]),
                     sat_add(sum_fld(sum_rdata, 1), nrm[1]),
                     sat_add(sum_fld(sum_rdata, 2), nrm[2])};
      end
      default: ;
    endcase
    stat_o.init_done = (state_q != B_CLEAR);
    stat_o.pop       = pop;
    result_valid_o   = res_valid_q;
    result_o         = res_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      mcnt_q      <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + VIDX_W'(1);
      end
      if (state_q == B_MUL) begin
        mcnt_q <= mcnt_q + 3'd1;
      end else begin
        mcnt_q <= '0;
      end
      if (state_q == B_ACCW) begin
        k_q <= k_q + 2'd1;
      end else if (state_q == B_IDLE) begin
        k_q <= '0;
      end
      res_valid_q <= (state_q == B_OUTZ) ||
                     (state_q == B_NWAIT && nrm_done && cmd_q.op == OP_READ);
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q <= cmd_i;
        end
      end
      B_RDB: for (int i = 0; i < 3; i++) pa_q[i] <= pos_fld(pos_rdata, i);
      B_RDC: for (int i = 0; i < 3; i++) pb_q[i] <= pos_fld(pos_rdata, i);
      B_RDW: for (int i = 0; i < 3; i++) pc_q[i] <= pos_fld(pos_rdata, i);
      B_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EDGE_W'(pc_q[i]) - EDGE_W'(pa_q[i]);
          e2_q[i] <= EDGE_W'(pb_q[i]) - EDGE_W'(pa_q[i]);
        end
      end
      B_MUL: begin
        prod_q <= op_a * op_b;
        // first product of a pair loads, second subtracts
        if (mcnt_q != 3'd0) begin
          if (mj[0]) begin
            vec_q[mj[2:1]] <= vec_q[mj[2:1]] - VEC_W'(prod_q);
          end else begin
            vec_q[mj[2:1]] <= VEC_W'(prod_q);
          end
        end
      end
      B_RDSW: for (int i = 0; i < 3; i++) vec_q[i] <= VEC_W'(sum_fld(sum_rdata, i));
      B_NWAIT: begin
        if (nrm_done) begin
          res_q.normal_x    <= nrm_zero ? '0 : nrm[0];
          res_q.normal_y    <= nrm_zero ? '0 : nrm[1];
          res_q.normal_z    <= nrm_zero ? '0 : nrm[2];
          res_q.zero_normal <= nrm_zero;
        end
      end
      B_OUTZ: begin
        res_q.normal_x    <= '0;
        res_q.normal_y    <= '0;
        res_q.normal_z    <= '0;
        res_q.zero_normal <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mva_checker.sv -----
// ----------------------------------------------------------------------------
// mva_checker: port-level checks for the normal accumulator
// Watches the result port for spacing and value consistency, and read intake right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input mva_pkg::in_item_t  item_i,
  input logic               result_valid_o,
  input mva_pkg::out_item_t result_o
);

  import mva_pkg::*;

  logic accepted;
  assign accepted = start && !busy && (item_i.kind == KIND_READ);

  // Results never come in adjacent cycles
  a_res_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back results");

  // A zero normal reports all components zero
  a_zero_vals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.zero_normal) |->
      (result_o.normal_x == 0 && result_o.normal_y == 0 && result_o.normal_z == 0))
    else $error("zero normal with nonzero components");

  // A valid normal has a nonzero component within unit range
  a_unit_vals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.zero_normal) |->
      ((result_o.normal_x != 0 || result_o.normal_y != 0 || result_o.normal_z != 0) &&
       result_o.normal_x <= 16384 && result_o.normal_x >= -16384 &&
       result_o.normal_y <= 16384 && result_o.normal_y >= -16384 &&
       result_o.normal_z <= 16384 && result_o.normal_z >= -16384))
    else $error("normal out of unit range");

  // First cycle after reset: no result, and the clearing sweep keeps reads out
  a_no_res_busy_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !result_valid_o && !accepted)
    else $error("activity right after reset");

endmodule

bind mesh_vertex_normal_accumulator mva_checker u_mva_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

`default_nettype wire
